// ===== hdl/hall_rpm_meter_macros.svh =====
// ----------------------------------------------------------------------------
// Hall tachometer assertion macros
// Immediate-style wrappers around concurrent checks, compiled out in synthesis.
// ----------------------------------------------------------------------------
`ifndef HALL_RPM_METER_MACROS_SVH
`define HALL_RPM_METER_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define HRM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hall_rpm_meter check failed");
// Consequent must hold in the cycle after the antecedent.
`define HRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hall_rpm_meter check failed");
`else
`define HRM_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define HRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/hrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Hall tachometer package
// Shared widths, reset values, request codes and the result record.
// ----------------------------------------------------------------------------
package hrm_pkg;

  localparam int COUNT_BITS_DEF  = 24;
  localparam int TIME_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int THR_W      = 12;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int HALF_W     = 24;
  localparam int MS_W       = 32;
  localparam int RPM_W      = 24;
  localparam int WIN_W      = 8;

  // Tenths of rpm per (half turn per millisecond): 60000 ms/min / 2 * 10.
  localparam int RPM_SCALE  = 300000;
  localparam int SCALE_BITS = 19;
  localparam int STEP_W     = $clog2(RPM_W);

  localparam logic [THR_W-1:0] LOW_THR_RST  = 12'd2979;
  localparam logic [THR_W-1:0] HIGH_THR_RST = 12'd3350;

  typedef enum logic [ACT_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_SWITCH = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THR  = 1'b0,
    REG_HIGH_THR = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              gate_on;
    logic              report_valid;
    logic [HALF_W-1:0] half_turns;
    logic [MS_W-1:0]   window_ms;
    logic [RPM_W-1:0]  rpm_tenths;
    logic [WIN_W-1:0]  window_number;
  } res_t;

endpackage

// ===== hdl/hrm_queue.sv =====
// ----------------------------------------------------------------------------
// Hall tachometer request queue
// Small flop-based FIFO between the classifying front and the divider back.
// ----------------------------------------------------------------------------
module hrm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CNT_FULL);
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/hrm_front.sv =====
// ----------------------------------------------------------------------------
// Hall tachometer front end
// Holds thresholds and counters, applies each request and queues its result.
// ----------------------------------------------------------------------------
module hrm_front import hrm_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [THR_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ACT_W-1:0]      action_i,
  input  logic [THR_W-1:0]      sample_i,
  input  logic                  full_i,
  output logic                  push_o,
  output res_t                  res_o,
  output logic [COUNT_BITS-1:0] count_o,
  output logic [TIME_BITS-1:0]  time_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [TIME_BITS-1:0]  TIME_MAX = '1;

  logic [THR_W-1:0]      low_thr_q, high_thr_q;
  logic                  gate_q, gate_d;
  logic                  arm_q, arm_d;
  logic [COUNT_BITS-1:0] half_q, half_d;
  logic [TIME_BITS-1:0]  ms_q, ms_d;
  logic [WIN_W-1:0]      win_q, win_d;

  logic                  n_hit, s_hit, arm_mid, report;
  logic [COUNT_BITS-1:0] half_mid;
  logic [HALF_W-1:0]     half_cap;
  logic [MS_W-1:0]       ms_cap;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    gate_d   = gate_q;
    arm_d    = arm_q;
    half_d   = half_q;
    ms_d     = ms_q;
    win_d    = win_q;
    report   = 1'b0;
    n_hit    = 1'b0;
    s_hit    = 1'b0;
    arm_mid  = arm_q;
    half_mid = half_q;
    unique case (action_e'(action_i))
      ACT_SAMPLE: begin
        // North test first, then south, so crossed thresholds may count twice.
        n_hit    = !arm_q && (sample_i < low_thr_q);
        half_mid = (n_hit && half_q != CNT_MAX) ? half_q + 1'b1 : half_q;
        arm_mid  = arm_q || n_hit;
        s_hit    = arm_mid && (sample_i > high_thr_q);
        half_d   = (s_hit && half_mid != CNT_MAX) ? half_mid + 1'b1 : half_mid;
        arm_d    = arm_mid && !s_hit;
      end
      ACT_SWITCH: begin
        if (!gate_q) begin
          gate_d = 1'b1;
          half_d = '0;
          ms_d   = '0;
          win_d  = win_q + 1'b1;
        end else begin
          gate_d = 1'b0;
          report = (half_q != '0) && (ms_q != '0);
        end
      end
      ACT_TICK: begin
        if (gate_q && ms_q != TIME_MAX) begin
          ms_d = ms_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  generate
    if (COUNT_BITS > HALF_W) begin : g_half_sat
      assign half_cap = (|half_d[COUNT_BITS-1:HALF_W]) ? '1 : half_d[HALF_W-1:0];
    end else begin : g_half_ext
      assign half_cap = HALF_W'(half_d);
    end
    if (TIME_BITS > MS_W) begin : g_ms_sat
      assign ms_cap = (|ms_d[TIME_BITS-1:MS_W]) ? '1 : ms_d[MS_W-1:0];
    end else begin : g_ms_ext
      assign ms_cap = MS_W'(ms_d);
    end
  endgenerate

  always_comb begin
    res_o.gate_on       = gate_d;
    res_o.report_valid  = report;
    res_o.half_turns    = half_cap;
    res_o.window_ms     = ms_cap;
    res_o.rpm_tenths    = '0;
    res_o.window_number = win_d;
  end

  assign count_o = half_d;
  assign time_o  = ms_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= LOW_THR_RST;
      high_thr_q <= HIGH_THR_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_LOW_THR:  low_thr_q  <= cfg_data_i;
        REG_HIGH_THR: high_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q <= 1'b0;
      arm_q  <= 1'b0;
      half_q <= '0;
      ms_q   <= '0;
      win_q  <= '0;
    end else if (push_o) begin
      gate_q <= gate_d;
      arm_q  <= arm_d;
      half_q <= half_d;
      ms_q   <= ms_d;
      win_q  <= win_d;
    end
  end

endmodule

// ===== hdl/hrm_back.sv =====
// ----------------------------------------------------------------------------
// Hall tachometer back end
// Drains the queue, divides for closing reports and holds the output register.
// ----------------------------------------------------------------------------
module hrm_back import hrm_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  output logic                  pop_o,
  input  res_t                  res_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic [TIME_BITS-1:0]  time_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output res_t                  out_res_o
);

  localparam int DW = COUNT_BITS + SCALE_BITS;
  localparam int SW = TIME_BITS + RPM_W;
  localparam int WW = (DW > SW) ? DW : SW;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RPM_W - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } bst_e;

  bst_e                  state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_res_q, out_res_d;
  res_t                  work_q, work_d;
  logic [COUNT_BITS-1:0] num_q, num_d;
  logic [TIME_BITS-1:0]  den_q, den_d;
  logic [DW-1:0]         prod_q, prod_d;
  logic [WW-1:0]         rem_q, rem_d;
  logic [WW-1:0]         dsh_q, dsh_d;
  logic [RPM_W-1:0]      quot_q, quot_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  out_free, ge;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign ge          = (rem_q >= dsh_q);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_res_d   = out_res_q;
    work_d      = work_q;
    num_d       = num_q;
    den_d       = den_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    quot_d      = quot_q;
    step_d      = step_q;
    pop_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          if (res_i.report_valid) begin
            pop_o   = 1'b1;
            work_d  = res_i;
            num_d   = count_i;
            den_d   = time_i;
            state_d = ST_MUL;
          end else if (out_free) begin
            pop_o       = 1'b1;
            out_res_d   = res_i;
            out_valid_d = 1'b1;
          end
        end
      end
      ST_MUL: begin
        prod_d  = DW'(num_q) * DW'(RPM_SCALE);
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // A quotient of 2^24 or more saturates without iterating.
        if (WW'(prod_q) >= WW'({den_q, {RPM_W{1'b0}}})) begin
          quot_d  = '1;
          state_d = ST_OUT;
        end else begin
          rem_d   = WW'(prod_q);
          dsh_d   = WW'({den_q, {(RPM_W-1){1'b0}}});
          quot_d  = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = ge ? rem_q - dsh_q : rem_q;
        quot_d = {quot_q[RPM_W-2:0], ge};
        dsh_d  = dsh_q >> 1;
        step_d = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_res_d            = work_q;
          out_res_d.rpm_tenths = quot_q;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
    work_q    <= work_d;
    num_q     <= num_d;
    den_q     <= den_d;
    prod_q    <= prod_d;
    rem_q     <= rem_d;
    dsh_q     <= dsh_d;
    quot_q    <= quot_d;
    step_q    <= step_d;
  end

endmodule

// ===== hdl/hall_rpm_meter.sv =====
// ----------------------------------------------------------------------------
// Hall sensor tachometer
// Each input request is a sensor sample, a switch press or a 1 ms tick; every
// request yields exactly one result carrying the gate, counts and window number.
// Configuration: cfg_we_i writes cfg_data_i into the low (index 0) or high
// (index 1) threshold; write only while no request is in flight.
// A plain result is registered in the queue and then in the output register
// after its request is accepted; a report that closes a window also goes
// through the serial divider, whose divide steps are skipped when the rate
// saturates.
// Throughput: one request per cycle while the queue is not full; a closing
// report holds the back end for the pop, one multiply, one range check, 24
// restoring divide steps and one output load, while the front keeps accepting
// until the queue fills.
// Reset clears the gate, arming, counters, window number and thresholds to
// their defaults; no result is pending afterwards.
// A stall on the output holds the result register; the queue then fills and
// in_stall_o rises, so no request is lost.
// ----------------------------------------------------------------------------
`include "hall_rpm_meter_macros.svh"

module hall_rpm_meter import hrm_pkg::*; #(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [THR_W-1:0]     cfg_data_i,
  // Request channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ACT_W-1:0]     action_i,
  input  logic [THR_W-1:0]     sample_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 gate_on_o,
  output logic                 report_valid_o,
  output logic [HALF_W-1:0]    half_turns_o,
  output logic [MS_W-1:0]      window_ms_o,
  output logic [RPM_W-1:0]     rpm_tenths_o,
  output logic [WIN_W-1:0]     window_number_o
);

  // A queue entry is the finished result record plus the raw, unsaturated
  // counts that the divider needs for a closing report.
  localparam int RES_W   = $bits(res_t);
  localparam int ENTRY_W = RES_W + COUNT_BITS + TIME_BITS;

  logic                  push, pop, full, empty;
  res_t                  f_res, q_res, o_res;
  logic [COUNT_BITS-1:0] f_count, q_count;
  logic [TIME_BITS-1:0]  f_time, q_time;
  logic [ENTRY_W-1:0]    push_data, pop_data;

  // The front applies each request to the counters in the cycle it is taken.
  hrm_front #(
    .COUNT_BITS(COUNT_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .sample_i   (sample_i),
    .full_i     (full),
    .push_o     (push),
    .res_o      (f_res),
    .count_o    (f_count),
    .time_o     (f_time)
  );

  assign push_data = {f_res, f_count, f_time};

  hrm_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  assign q_res   = res_t'(pop_data[ENTRY_W-1 -: RES_W]);
  assign q_count = pop_data[TIME_BITS +: COUNT_BITS];
  assign q_time  = pop_data[TIME_BITS-1:0];

  // The back end passes plain results straight to the output register and
  // runs the rate division only for a valid closing report.
  hrm_back #(
    .COUNT_BITS(COUNT_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_o      (pop),
    .res_i      (q_res),
    .count_i    (q_count),
    .time_i     (q_time),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (o_res)
  );

  assign gate_on_o       = o_res.gate_on;
  assign report_valid_o  = o_res.report_valid;
  assign half_turns_o    = o_res.half_turns;
  assign window_ms_o     = o_res.window_ms;
  assign rpm_tenths_o    = o_res.rpm_tenths;
  assign window_number_o = o_res.window_number;

  // A report only ever comes from a close, so the gate is shut with it.
  `HRM_ASSERT_SAME(a_report_closed, clk_i, rst_ni, out_valid_o && report_valid_o, !gate_on_o)
  // Only a valid report carries a nonzero rate.
  `HRM_ASSERT_SAME(a_rpm_needs_report, clk_i, rst_ni,
                   out_valid_o && (rpm_tenths_o != '0), report_valid_o)
  // A valid report implies nonzero count and time.
  `HRM_ASSERT_SAME(a_report_nonzero, clk_i, rst_ni, out_valid_o && report_valid_o,
                   (half_turns_o != '0) && (window_ms_o != '0))

endmodule

// ===== tb/sv/hall_rpm_meter_tb.sv =====
// ----------------------------------------------------------------------------
// Hall tachometer testbench
// Drives sensor samples, switch presses and millisecond ticks into the meter.
// A behavioral copy of the tachometer predicts each result, and every result
// is checked field by field in arrival order. A short scripted sequence comes
// first. Random phases under several threshold settings follow, with idle
// cycles and output stalls inserted at random.
// ----------------------------------------------------------------------------
module hall_rpm_meter_tb;
  import hrm_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;   // covers the serial divider of a close
  localparam int IDLE_PCT     = 32;
  localparam int PHASE_ITEMS  = 90;
  localparam int SCRIPT_LEN   = 29;
  localparam logic [THR_W-1:0] CODE_MAX = '1;

  // One scripted step: either a threshold write or a request. The expected
  // result is typed in only where it is obvious; other rows use the predictor.
  typedef struct {
    bit               is_cfg;
    reg_idx_e         idx;
    action_e          act;
    logic [THR_W-1:0] code;
    bit               typed;
    res_t             want;
  } script_row_t;

  localparam res_t UNCHECKED = '0;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             cfg_we     = 1'b0;
  reg_idx_e         cfg_index  = REG_LOW_THR;
  logic [THR_W-1:0] cfg_data   = '0;
  logic             in_valid   = 1'b0;
  logic             in_stall;
  action_e          req_action = ACT_SAMPLE;
  logic [THR_W-1:0] req_sample = '0;
  logic             out_valid;
  logic             out_stall  = 1'b0;
  logic             gate_on;
  logic             report_valid;
  logic [HALF_W-1:0] half_turns;
  logic [MS_W-1:0]   window_ms;
  logic [RPM_W-1:0]  rpm_tenths;
  logic [WIN_W-1:0]  window_number;

  // Predicted tachometer state, kept in step with the accepted requests.
  logic [THR_W-1:0]  low_thr_q  = LOW_THR_RST;
  logic [THR_W-1:0]  high_thr_q = HIGH_THR_RST;
  logic              gate_q     = 1'b0;
  logic              north_q    = 1'b0;
  logic [HALF_W-1:0] half_q     = '0;
  logic [MS_W-1:0]   ms_q       = '0;
  logic [WIN_W-1:0]  win_q      = '0;

  res_t pending_readings[$];
  int   errors    = 0;
  int   cycle_cnt = 0;
  bit   calm      = 1'b0;  // when set, neither side idles

  // Scripted opening sequence. Thresholds start at their reset values.
  script_row_t script [SCRIPT_LEN] = '{
    // Right after reset everything reads zero, and an unused code changes nothing.
    '{0, REG_LOW_THR, ACT_NONE,   12'd0,    1, res_t'{1'b0, 1'b0, 24'd0, 32'd0, 24'd0, 8'd0}},
    // A tick while the window is closed is ignored.
    '{0, REG_LOW_THR, ACT_TICK,   12'd0,    1, res_t'{1'b0, 1'b0, 24'd0, 32'd0, 24'd0, 8'd0}},
    // Samples are counted even while the window is closed.
    '{0, REG_LOW_THR, ACT_SAMPLE, 12'd0,    1, res_t'{1'b0, 1'b0, 24'd1, 32'd0, 24'd0, 8'd0}},
    '{0, REG_LOW_THR, ACT_SAMPLE, 12'd4095, 1, res_t'{1'b0, 1'b0, 24'd2, 32'd0, 24'd0, 8'd0}},
    // Opening clears the counts; an immediate close is an invalid report.
    '{0, REG_LOW_THR, ACT_SWITCH, 12'd0,    1, res_t'{1'b1, 1'b0, 24'd0, 32'd0, 24'd0, 8'd1}},
    '{0, REG_LOW_THR, ACT_SWITCH, 12'd0,    1, res_t'{1'b0, 1'b0, 24'd0, 32'd0, 24'd0, 8'd1}},
    '{0, REG_LOW_THR, ACT_SWITCH, 12'd0,    1, res_t'{1'b1, 1'b0, 24'd0, 32'd0, 24'd0, 8'd2}},
    '{0, REG_LOW_THR, ACT_TICK,   12'd0,    0, UNCHECKED},
    // Samples right on a threshold do not count; one code past it does.
    '{0, REG_LOW_THR, ACT_SAMPLE, 12'd2979, 0, UNCHECKED},
    '{0, REG_LOW_THR, ACT_SAMPLE, 12'd2978, 0, UNCHECKED},
    '{0, REG_LOW_THR, ACT_SAMPLE, 12'd3350, 0, UNCHECKED},
    '{0, REG_LOW_THR, ACT_SAMPLE, 12'd3351, 0, UNCHECKED},
    '{0, REG_LOW_THR, ACT_SAMPLE, 12'd0,    0, UNCHECKED},
    '{0, REG_LOW_THR, ACT_SAMPLE, 12'd4095, 0, UNCHECKED},
    '{0, REG_LOW_THR, ACT_NONE,   12'd4095, 0, UNCHECKED},
    // Four half turns in one millisecond.
    '{0, REG_LOW_THR, ACT_SWITCH, 12'd0,    1,
      res_t'{1'b0, 1'b1, 24'd4, 32'd1, 24'd1200000, 8'd2}},
    '{0, REG_LOW_THR, ACT_SWITCH, 12'd0,    1, res_t'{1'b1, 1'b0, 24'd0, 32'd0, 24'd0, 8'd3}},
    '{0, REG_LOW_THR, ACT_TICK,   12'd0,    0, UNCHECKED},
    // Time without any count is also an invalid report.
    '{0, REG_LOW_THR, ACT_SWITCH, 12'd0,    1, res_t'{1'b0, 1'b0, 24'd0, 32'd1, 24'd0, 8'd3}},
    // Widest hysteresis: no code is ever past either threshold.
    '{1, REG_LOW_THR,  ACT_NONE,  12'd0,    0, UNCHECKED},
    '{1, REG_HIGH_THR, ACT_NONE,  12'd4095, 0, UNCHECKED},
    '{0, REG_LOW_THR, ACT_SWITCH, 12'd0,    1, res_t'{1'b1, 1'b0, 24'd0, 32'd0, 24'd0, 8'd4}},
    '{0, REG_LOW_THR, ACT_SAMPLE, 12'd0,    0, UNCHECKED},
    '{0, REG_LOW_THR, ACT_SAMPLE, 12'd4095, 0, UNCHECKED},
    // Crossed thresholds: a single sample counts twice.
    '{1, REG_LOW_THR,  ACT_NONE,  12'd4095, 0, UNCHECKED},
    '{1, REG_HIGH_THR, ACT_NONE,  12'd0,    0, UNCHECKED},
    '{0, REG_LOW_THR, ACT_SAMPLE, 12'd2048, 0, UNCHECKED},
    '{0, REG_LOW_THR, ACT_TICK,   12'd0,    0, UNCHECKED},
    '{0, REG_LOW_THR, ACT_SWITCH, 12'd0,    1,
      res_t'{1'b0, 1'b1, 24'd2, 32'd1, 24'd600000, 8'd4}}
  };

  hall_rpm_meter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .action_i        (req_action),
    .sample_i        (req_sample),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .gate_on_o       (gate_on),
    .report_valid_o  (report_valid),
    .half_turns_o    (half_turns),
    .window_ms_o     (window_ms),
    .rpm_tenths_o    (rpm_tenths),
    .window_number_o (window_number)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Applies one accepted request to the predicted state and returns the
  // result the meter should produce for it.
  function automatic res_t advance_tachometer(action_e act, logic [THR_W-1:0] code);
    res_t        r;
    logic [63:0] quot;
    r = '0;
    case (act)
      ACT_SAMPLE: begin
        // The north test runs first, so crossed thresholds can count twice.
        if (!north_q && code < low_thr_q) begin
          if (half_q != '1) half_q = half_q + 1'b1;
          north_q = 1'b1;
        end
        if (north_q && code > high_thr_q) begin
          if (half_q != '1) half_q = half_q + 1'b1;
          north_q = 1'b0;
        end
      end
      ACT_SWITCH: begin
        if (!gate_q) begin
          // Opening keeps the arming as it is.
          gate_q = 1'b1;
          half_q = '0;
          ms_q   = '0;
          win_q  = win_q + 1'b1;
        end else begin
          gate_q = 1'b0;
          if (half_q != '0 && ms_q != '0) begin
            quot           = (64'(half_q) * 64'(RPM_SCALE)) / 64'(ms_q);
            r.report_valid = 1'b1;
            r.rpm_tenths   = (quot > 64'hFF_FFFF) ? '1 : quot[RPM_W-1:0];
          end
        end
      end
      ACT_TICK: begin
        if (gate_q && ms_q != '1) ms_q = ms_q + 1'b1;
      end
      default: begin
      end
    endcase
    r.gate_on       = gate_q;
    r.half_turns    = half_q;
    r.window_ms     = ms_q;
    r.window_number = win_q;
    return r;
  endfunction

  // Presents one request, holding it until the meter takes it, and records
  // the result it should produce. Random idle cycles come first.
  task automatic send_request(action_e act, logic [THR_W-1:0] code, bit typed = 1'b0,
                              res_t want = '0);
    res_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    req_action <= act;
    req_sample <= code;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predicted = advance_tachometer(act, code);
    pending_readings.push_back(typed ? want : predicted);
  endtask

  // Writes one threshold once every outstanding result has come back.
  task automatic load_threshold(reg_idx_e idx, logic [THR_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    if (idx == REG_LOW_THR) low_thr_q = val;
    else high_thr_q = val;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // One random phase under a fixed pair of thresholds. Most of the traffic is
  // complete windows whose samples swing across the hysteresis band, so counts
  // build up and the rate saturates now and then; the rest is runs of switch
  // presses and unstructured noise.
  task automatic random_phase(logic [THR_W-1:0] lo, logic [THR_W-1:0] hi);
    int done;
    int kind;
    int n_ticks;
    int n_codes;
    int burst;
    int pick;
    load_threshold(REG_LOW_THR, lo);
    load_threshold(REG_HIGH_THR, hi);
    done = 0;
    while (done < PHASE_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        if (gate_q) begin
          send_request(ACT_SWITCH, THR_W'($urandom_range(CODE_MAX)));
          done++;
        end
        send_request(ACT_SWITCH, THR_W'($urandom_range(CODE_MAX)));
        n_ticks = ($urandom_range(99) < 10) ? 0 : $urandom_range(4, 1);
        n_codes = ($urandom_range(99) < 15) ? $urandom_range(90, 30) : $urandom_range(12, 0);
        while (n_ticks + n_codes > 0) begin
          if (n_ticks > 0 && $urandom_range(n_ticks + n_codes - 1) < n_ticks) begin
            send_request(ACT_TICK, THR_W'($urandom_range(CODE_MAX)));
            n_ticks--;
          end else begin
            n_codes--;
            pick = $urandom_range(99);
            if (pick < 5) begin
              send_request(ACT_NONE, THR_W'($urandom_range(CODE_MAX)));
            end else if (pick < 15) begin
              send_request(ACT_SAMPLE, THR_W'($urandom_range(CODE_MAX)));
            end else if (!north_q && low_thr_q != '0) begin
              send_request(ACT_SAMPLE, THR_W'($urandom_range(low_thr_q - 1, 0)));
            end else if (north_q && high_thr_q != CODE_MAX) begin
              send_request(ACT_SAMPLE, THR_W'($urandom_range(CODE_MAX, high_thr_q + 1)));
            end else begin
              send_request(ACT_SAMPLE, THR_W'($urandom_range(CODE_MAX)));
            end
          end
          done++;
        end
        send_request(ACT_SWITCH, THR_W'($urandom_range(CODE_MAX)));
        done += 2;
      end else if (kind < 80) begin
        // Quick toggling walks the window number along its range.
        burst = $urandom_range(60, 20);
        repeat (burst) send_request(ACT_SWITCH, THR_W'($urandom_range(CODE_MAX)));
        done += burst;
      end else begin
        burst = $urandom_range(10, 1);
        repeat (burst) begin
          send_request(action_e'($urandom_range(3)), THR_W'($urandom_range(CODE_MAX)));
        end
        done += burst;
      end
    end
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result side: every result taken is matched against the oldest prediction.
  // The output stall is redrawn each cycle.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("result arrived with no request pending");
        errors++;
      end else begin
        want = pending_readings.pop_front();
        check_field("gate_on", 64'(want.gate_on), 64'(gate_on));
        check_field("report_valid", 64'(want.report_valid), 64'(report_valid));
        check_field("half_turns", 64'(want.half_turns), 64'(half_turns));
        check_field("window_ms", 64'(want.window_ms), 64'(window_ms));
        check_field("rpm_tenths", 64'(want.rpm_tenths), 64'(rpm_tenths));
        check_field("window_number", 64'(want.window_number), 64'(window_number));
      end
    end
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int lo_pick;
    int hi_pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        load_threshold(script[i].idx, script[i].code);
      end else begin
        send_request(script[i].act, script[i].code, script[i].typed, script[i].want);
      end
    end

    // Reset values, then an ordinary random band.
    random_phase(LOW_THR_RST, HIGH_THR_RST);
    lo_pick = $urandom_range(2000, 100);
    hi_pick = $urandom_range(4000, lo_pick + 1);
    random_phase(THR_W'(lo_pick), THR_W'(hi_pick));

    // Crossed thresholds, run back to back with no idling on either side.
    hi_pick = $urandom_range(2000, 0);
    lo_pick = $urandom_range(4095, hi_pick + 1);
    calm = 1'b1;
    random_phase(THR_W'(lo_pick), THR_W'(hi_pick));
    calm = 1'b0;

    // Both extremes, then a fully random pair.
    random_phase(12'd0, 12'd4095);
    random_phase(12'd4095, 12'd0);
    random_phase(THR_W'($urandom_range(4095)), THR_W'($urandom_range(4095)));

    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
